// ----- rtl/console_line_editor_top_assert.svh -----
`ifndef CONSOLE_LINE_EDITOR_TOP_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define CLE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/cle_pkg.sv -----
package cle_pkg;

	localparam int LINE_CAPACITY = 32;
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int FILL_W        = $clog2(LINE_CAPACITY + 1);
	localparam int CHAR_W        = 8;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W     = 1;

	localparam logic [CHAR_W-1:0]    SPACE_CODE    = 8'h20;
	localparam logic [CHAR_W-1:0]    BS_RESET      = 8'd8;
	localparam logic [CHAR_W-1:0]    ENTER_RESET   = 8'd13;
	localparam logic [CFG_IDX_W-1:0] REG_BACKSPACE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER     = 1'b1;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_ECHO,
		OP_LINE
	} op_t;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ECHO,
		B_LINE
	} bstate_t;

	typedef struct packed {
		op_t                op;
		logic [FILL_W-1:0]  len;
		logic [CHAR_W-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_rd_t;

endpackage

// ----- rtl/console_line_editor_top.sv -----
// Console line editor: builds a line, echoes backspace, reads the line out on Enter.
// Throughput: one input word per cycle while the two-entry command queue has room.
// The back end stores each character in the line memory, emits two words per backspace
// and one word per line character on Enter (one for an empty line, 31 for a full line).
// A result word passes through the command queue, stage s1 and the output register.
// Reset (arst_n low): clears fill count, queue, state and output valid; codes go to 8 and 13.
module console_line_editor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] char_in
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] data_byte
	output logic                           m_tlast,
	output logic [1:0]                     m_tuser,   // [1:0] kind
	input  logic                           cfg_we,
	input  logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);

	cle_pkg::q_wr_t q_wr;
	cle_pkg::q_rd_t q_rd;
	logic           q_full;
	logic           pop;

	cle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	cle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.pop    (pop)
	);

	cle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/cle_front.sv -----
module cle_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cle_pkg::CHAR_W-1:0]     s_tdata,
	input  logic                           cfg_we,
	input  logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cle_pkg::CHAR_W-1:0]     cfg_data,
	input  logic                           q_full,
	output cle_pkg::q_wr_t                 q_wr
);

	logic [cle_pkg::FILL_W-1:0] fill_q;
	logic [cle_pkg::FILL_W-1:0] fill_d;
	logic [cle_pkg::CHAR_W-1:0] bs_code_q;
	logic [cle_pkg::CHAR_W-1:0] enter_code_q;
	logic                       accept;
	logic                       push;
	cle_pkg::cmd_t              cmd;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		fill_d   = fill_q;
		push     = 1'b0;
		cmd.op   = cle_pkg::OP_STORE;
		cmd.len  = fill_q;
		cmd.data = s_tdata;
		if (fill_q == cle_pkg::FILL_W'(cle_pkg::LINE_CAPACITY)) begin
			// full line: only Enter counts, and the last stored byte is dropped
			if (s_tdata == enter_code_q) begin
				push    = 1'b1;
				cmd.op  = cle_pkg::OP_LINE;
				cmd.len = cle_pkg::FILL_W'(cle_pkg::LINE_CAPACITY - 1);
				fill_d  = '0;
			end
		end else if (s_tdata == bs_code_q) begin
			if (fill_q != '0) begin
				push     = 1'b1;
				cmd.op   = cle_pkg::OP_ECHO;
				cmd.data = bs_code_q;
				fill_d   = fill_q - cle_pkg::FILL_W'(1);
			end
		end else if (s_tdata == enter_code_q) begin
			push   = 1'b1;
			cmd.op = cle_pkg::OP_LINE;
			fill_d = '0;
		end else begin
			push   = 1'b1;
			fill_d = fill_q + cle_pkg::FILL_W'(1);
		end
	end

	assign q_wr.push = push && accept;
	assign q_wr.cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_code_q    <= cle_pkg::BS_RESET;
			enter_code_q <= cle_pkg::ENTER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cle_pkg::REG_BACKSPACE: bs_code_q    <= cfg_data;
				cle_pkg::REG_ENTER:     enter_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/cle_queue.sv -----
module cle_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  cle_pkg::q_wr_t q_wr,
	output logic           q_full,
	output cle_pkg::q_rd_t q_rd,
	input  logic           pop
);

	cle_pkg::cmd_t              entry_q [cle_pkg::QUEUE_DEPTH];
	logic [cle_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [cle_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [cle_pkg::QCNT_W-1:0] count_q;
	logic                       do_push;
	logic                       do_pop;

	assign q_full    = count_q == cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH);
	assign q_rd.valid = count_q != '0;
	assign q_rd.cmd  = entry_q[rd_ptr_q];
	assign do_push   = q_wr.push && !q_full;
	assign do_pop    = pop && q_rd.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == cle_pkg::QPTR_W'(cle_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + cle_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == cle_pkg::QPTR_W'(cle_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + cle_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + cle_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - cle_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/cle_back.sv -----
`include "console_line_editor_top_assert.svh"

module cle_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cle_pkg::q_rd_t             q_rd,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cle_pkg::CHAR_W-1:0] m_tdata,
	output logic                       m_tlast,
	output logic [1:0]                 m_tuser
);

	logic [cle_pkg::CHAR_W-1:0] mem [cle_pkg::LINE_CAPACITY];

	cle_pkg::bstate_t           state_q;
	cle_pkg::bstate_t           state_d;
	logic [cle_pkg::ADDR_W-1:0] idx_q;
	logic [cle_pkg::FILL_W-1:0] len_q;
	logic [cle_pkg::CHAR_W-1:0] code_q;
	logic [cle_pkg::FILL_W-1:0] idx_next;

	logic                       s1_valid_q;
	cle_pkg::kind_t             kind_s1;
	logic                       ram_s1;
	logic [cle_pkg::CHAR_W-1:0] data_s1;
	logic                       last_s1;
	logic [cle_pkg::CHAR_W-1:0] rd_data_s1;

	logic                       out_valid_q;
	cle_pkg::kind_t             out_kind_q;
	logic [cle_pkg::CHAR_W-1:0] out_data_q;
	logic                       out_last_q;

	logic                       adv;
	logic                       load_out;
	logic                       mem_we;
	logic                       rd_en;
	logic [cle_pkg::ADDR_W-1:0] rd_addr;
	logic                       push;
	cle_pkg::kind_t             push_kind;
	logic                       push_ram;
	logic [cle_pkg::CHAR_W-1:0] push_data;
	logic                       push_last;

	assign load_out = s1_valid_q && (!out_valid_q || m_tready);
	assign adv      = !s1_valid_q || load_out;
	assign idx_next = cle_pkg::FILL_W'(idx_q) + cle_pkg::FILL_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cle_pkg::B_IDLE: begin
				if (q_rd.valid && adv) begin
					if (q_rd.cmd.op == cle_pkg::OP_ECHO) begin
						state_d = cle_pkg::B_ECHO;
					end else if (q_rd.cmd.op == cle_pkg::OP_LINE &&
					             q_rd.cmd.len > cle_pkg::FILL_W'(1)) begin
						state_d = cle_pkg::B_LINE;
					end
				end
			end
			cle_pkg::B_ECHO: begin
				if (adv) begin
					state_d = cle_pkg::B_IDLE;
				end
			end
			cle_pkg::B_LINE: begin
				if (adv && idx_next == len_q) begin
					state_d = cle_pkg::B_IDLE;
				end
			end
			default: state_d = cle_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		push      = 1'b0;
		push_kind = cle_pkg::KIND_ECHO;
		push_ram  = 1'b0;
		push_data = cle_pkg::SPACE_CODE;
		push_last = 1'b0;
		case (state_q)
			cle_pkg::B_IDLE: begin
				if (q_rd.valid) begin
					case (q_rd.cmd.op)
						cle_pkg::OP_STORE: begin
							pop    = 1'b1;
							mem_we = 1'b1;
						end
						cle_pkg::OP_ECHO: begin
							pop  = adv;
							push = adv;
						end
						cle_pkg::OP_LINE: begin
							pop  = adv;
							push = adv;
							if (q_rd.cmd.len == '0) begin
								push_kind = cle_pkg::KIND_EMPTY;
								push_data = '0;
								push_last = 1'b1;
							end else begin
								rd_en     = adv;
								rd_addr   = '0;
								push_kind = cle_pkg::KIND_LINE;
								push_ram  = 1'b1;
								push_last = q_rd.cmd.len == cle_pkg::FILL_W'(1);
							end
						end
						default: ;
					endcase
				end
			end
			cle_pkg::B_ECHO: begin
				push      = adv;
				push_data = code_q;
				push_last = 1'b1;
			end
			cle_pkg::B_LINE: begin
				push      = adv;
				rd_en     = adv;
				push_kind = cle_pkg::KIND_LINE;
				push_ram  = 1'b1;
				push_last = idx_next == len_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_rd.cmd.len[cle_pkg::ADDR_W-1:0]] <= q_rd.cmd.data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cle_pkg::B_IDLE && pop) begin
			code_q <= q_rd.cmd.data;
			len_q  <= q_rd.cmd.len;
			idx_q  <= cle_pkg::ADDR_W'(1);
		end else if (state_q == cle_pkg::B_LINE && adv) begin
			idx_q  <= idx_q + cle_pkg::ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= push_kind;
			ram_s1  <= push_ram;
			data_s1 <= push_data;
			last_s1 <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q <= kind_s1;
			out_data_q <= ram_s1 ? rd_data_s1 : data_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;

	`CLE_ASSERT(a_idx_in_line, state_q != cle_pkg::B_LINE || idx_next <= len_q, "line index past length")
	`CLE_ASSERT(a_write_idle, !mem_we || state_q == cle_pkg::B_IDLE, "store written outside idle")
	`CLE_ASSERT(a_pop_idle, !pop || state_q == cle_pkg::B_IDLE, "queue popped while busy")
	`CLE_ASSERT_NEXT(a_echo_pair, state_q == cle_pkg::B_ECHO && adv, s1_valid_q && last_s1 && kind_s1 == cle_pkg::KIND_ECHO, "echo pair broken")

endmodule
